>>> src/upd_pkg.sv
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

   // decoupling queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // most decoded bytes that one input beat can cause
   localparam int MAX_OUT = 3;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_type;

   // one queue entry: the decoded bytes that one input beat produced
   typedef struct packed {
      logic [1:0]                  count;  // 1..3
      logic [MAX_OUT-1:0][7:0]     bytes;  // bytes[0] goes out first
      logic                        last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_hex(input logic [7:0] b);
      is_hex = (b >= 8'h30 && b <= 8'h39) ||
               (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
   endfunction

   // nibble value of a hex digit; only meaningful where is_hex holds
   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] t;
      begin
         if (b <= 8'h39) begin
            t = b - 8'h30;
            hex_nibble = t[3:0];
         end else if (b <= 8'h46) begin
            t = b - 8'h41;
            hex_nibble = t[3:0] + HEX_ALPHA_BASE;
         end else begin
            t = b - 8'h61;
            hex_nibble = t[3:0] + HEX_ALPHA_BASE;
         end
      end
   endfunction

endpackage

>>> src/url_percent_decoder_core.sv
// URL percent decoder (form-urlencoded style).
// Input channel req_*: one raw byte per beat, req_last on the final byte.
// Result channel rsp_*: decoded bytes in order, rsp_last on the final one.
// "%hh" (either case) becomes one byte, '+' becomes a space, other bytes
// pass unchanged. A broken escape or one cut off by req_last is flushed
// literally.
// Structure: a front stage decodes each beat into 0..3 output bytes and
// pushes them as one entry into a 4-entry queue; a back stage drains one
// byte per cycle, while rsp_stall is low, into the output register.
// A decoded byte goes into a queue entry, then into the output register.
// Throughput: one input beat per cycle while rsp_stall is low and each
// beat yields at most one byte; a beat that yields k bytes holds the back
// stage until all k are sent, and req_stall rises once the queue fills.
// A '%' or first hex digit not on a last beat adds no byte of its own.
// Reset (synchronous): escape state cleared, queue emptied, rsp_valid low.
// While rsp_stall is high the output beat holds; the queue keeps taking
// beats until full.
module url_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);
   import upd_pkg::*;

   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         q_push;
   logic         q_pop;

   // input side stalls only on a full queue
   assign req_stall = q_status.full;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   upd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last),
      .rsp_stall (rsp_stall)
   );

endmodule

>>> src/upd_front.sv
module upd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_byte,
   input  logic             req_last,
   input  upd_pkg::q_status_type q_status,
   output logic             q_push,
   output upd_pkg::cmd_type q_cmd
);
   import upd_pkg::*;

   pend_type   pend_ff, pend_in;
   logic [7:0] held_ff, held_in;

   logic       accept;
   logic       hex;
   logic       do_plain;
   logic       p_emit;
   logic [7:0] p_byte;
   logic       p_hold;
   cmd_type    cmd;

   assign accept = req_valid && !q_status.full;
   assign hex    = is_hex(req_byte);

   // byte handled with nothing held
   always_comb begin
      p_emit = 1'b1;
      p_hold = 1'b0;
      p_byte = req_byte;
      if (req_byte == CH_PERCENT) begin
         if (!req_last) begin
            p_emit = 1'b0;
            p_hold = 1'b1;
         end
      end else if (req_byte == CH_PLUS) begin
         p_byte = CH_SPACE;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.last = req_last;
      pend_in  = PEND_NONE;
      held_in  = held_ff;
      do_plain = 1'b0;

      unique case (pend_ff)
         PEND_PCT: begin
            if (hex) begin
               if (req_last) begin
                  cmd.count    = 2'd2;
                  cmd.bytes[0] = CH_PERCENT;
                  cmd.bytes[1] = req_byte;
               end else begin
                  held_in = req_byte;
                  pend_in = PEND_DIGIT;
               end
            end else begin
               // broken escape: flush '%' then treat byte as fresh
               cmd.count    = p_emit ? 2'd2 : 2'd1;
               cmd.bytes[0] = CH_PERCENT;
               cmd.bytes[1] = p_byte;
               do_plain     = 1'b1;
            end
         end
         PEND_DIGIT: begin
            if (hex) begin
               cmd.count    = 2'd1;
               cmd.bytes[0] = {hex_nibble(held_ff), hex_nibble(req_byte)};
            end else begin
               cmd.count    = p_emit ? 2'd3 : 2'd2;
               cmd.bytes[0] = CH_PERCENT;
               cmd.bytes[1] = held_ff;
               cmd.bytes[2] = p_byte;
               do_plain     = 1'b1;
            end
         end
         PEND_NONE: begin
            cmd.count    = p_emit ? 2'd1 : 2'd0;
            cmd.bytes[0] = p_byte;
            do_plain     = 1'b1;
         end
         default: begin
            pend_in = PEND_NONE;
         end
      endcase

      if (do_plain && p_hold) begin
         pend_in = PEND_PCT;
      end
      if (req_last) begin
         pend_in = PEND_NONE;
         held_in = '0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
         held_ff <= '0;
      end else if (accept) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (pend_ff == PEND_NONE))
      else $error("escape state not cleared after last beat");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |-> q_push)
      else $error("last beat produced no output");

   a_held_is_hex: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == PEND_DIGIT) |-> is_hex(held_ff))
      else $error("held digit is not hex");
`endif

endmodule

>>> src/upd_queue.sv
module upd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output upd_pkg::cmd_type head_cmd,
   output upd_pkg::q_status_type status
);
   import upd_pkg::*;

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign status.full  = (cnt_ff == QDEPTH[QPTR_W:0]);
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[QPTR_W-1:0] == wr_ptr_ff - rd_ptr_ff))
      else $error("queue count and pointers disagree");
`endif

endmodule

>>> src/upd_back.sv
module upd_back (
   input  logic             clock,
   input  logic             reset,
   input  upd_pkg::cmd_type head_cmd,
   input  upd_pkg::q_status_type q_status,
   output logic             q_pop,
   output logic             rsp_valid,
   output logic [7:0]       rsp_byte,
   output logic             rsp_last,
   input  logic             rsp_stall
);
   import upd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign load   = !valid_ff || !rsp_stall;
   assign at_end = (idx_ff == head_cmd.count - 2'd1);
   assign q_pop  = load && !q_status.empty && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            byte_in = head_cmd.bytes[idx_ff];
            last_in = head_cmd.last && at_end;
            idx_in  = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (idx_ff < head_cmd.count))
      else $error("byte index beyond entry");

   a_idx_rest: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (idx_ff == 2'd0))
      else $error("byte index not at rest with empty queue");

   a_pop_wraps: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (idx_ff == 2'd0))
      else $error("index not reset after pop");
`endif

endmodule
